// ----- src/cpu8_memory_operand_execute_top_defines.svh -----
// ---------------------------------------------------------------------------
// cpu8 memory-operand execute: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CPU8_MEMORY_OPERAND_EXECUTE_TOP_DEFINES_SVH
`define CPU8_MEMORY_OPERAND_EXECUTE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPU8MO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPU8MO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cpu8mo_pkg.sv -----
// ---------------------------------------------------------------------------
// cpu8mo_pkg
// Operation codes, decoded control types and constants of the execute unit.
// ---------------------------------------------------------------------------
package cpu8mo_pkg;

  // Default depth of the request queue between decode and execute.
  localparam int CPU8MO_QUEUE_DEPTH = 2;

  // Operation codes of an incoming request; codes 30 and 31 are unused.
  typedef enum logic [4:0] {
    OP_ADC = 5'd0,  OP_SBC = 5'd1,  OP_AND = 5'd2,  OP_ORA = 5'd3,
    OP_EOR = 5'd4,  OP_ASL = 5'd5,  OP_LSR = 5'd6,  OP_ROL = 5'd7,
    OP_ROR = 5'd8,  OP_BIT = 5'd9,  OP_JMP = 5'd10, OP_CMP = 5'd11,
    OP_CPX = 5'd12, OP_CPY = 5'd13, OP_INC = 5'd14, OP_DEC = 5'd15,
    OP_LDA = 5'd16, OP_LDX = 5'd17, OP_LDY = 5'd18, OP_STA = 5'd19,
    OP_STX = 5'd20, OP_STY = 5'd21, OP_LAX = 5'd22, OP_SAX = 5'd23,
    OP_DCP = 5'd24, OP_ISC = 5'd25, OP_SLO = 5'd26, OP_RLA = 5'd27,
    OP_SRE = 5'd28, OP_RRA = 5'd29
  } op_t;

  // Modification applied to the operand byte before the accumulator path.
  typedef enum logic [2:0] {
    MOD_NONE = 3'd0, MOD_ASL = 3'd1, MOD_LSR = 3'd2, MOD_ROL = 3'd3,
    MOD_ROR  = 3'd4, MOD_INC = 3'd5, MOD_DEC = 3'd6
  } mod_t;

  // Accumulator-path operation.
  typedef enum logic [3:0] {
    ALU_NONE = 4'd0, ALU_ADC = 4'd1, ALU_SBC = 4'd2, ALU_AND = 4'd3,
    ALU_ORA  = 4'd4, ALU_EOR = 4'd5, ALU_BIT = 4'd6, ALU_CMP = 4'd7,
    ALU_LOAD = 4'd8
  } alu_t;

  // Register compared against the operand.
  typedef enum logic [1:0] {
    REG_A = 2'd0, REG_X = 2'd1, REG_Y = 2'd2
  } reg_sel_t;

  // Source of the write-back byte.
  typedef enum logic [2:0] {
    WS_MOD = 3'd0, WS_A = 3'd1, WS_X = 3'd2, WS_Y = 3'd3, WS_AX = 3'd4
  } wsel_t;

  // Decoded control word of one request.
  typedef struct packed {
    mod_t     modify;
    alu_t     alu;
    reg_sel_t cmp_reg;
    wsel_t    wsel;
    logic     wen;
    logic     jump;
    logic     ld_a;
    logic     ld_x;
    logic     ld_y;
    logic     nz_mod;
  } ctrl_t;

  // One decoded request as it travels through the queue.
  typedef struct packed {
    ctrl_t       ctrl;
    logic [7:0]  operand;
    logic [15:0] address;
  } uop_t;

  // Head of the queue as seen by the execute stage.
  typedef struct packed {
    logic valid;
    uop_t uop;
  } q_head_t;

  // Flag bit positions in the packed flag word.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_V = 2;
  localparam int FLAG_N = 3;

endpackage

// ----- src/cpu8mo_front.sv -----
// ---------------------------------------------------------------------------
// cpu8mo_front
// Accepts requests and decodes the operation code into a control word.
// ---------------------------------------------------------------------------
module cpu8mo_front
  import cpu8mo_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_operation,
  input  logic [7:0]  in_operand_value,
  input  logic [15:0] in_operand_address,
  input  logic        q_full,
  output logic        push,
  output uop_t        push_uop
);

  ctrl_t ctrl;

  // The queue applies back-pressure directly to the input channel.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the operation.
  always_comb begin
    ctrl         = '0;
    ctrl.modify  = MOD_NONE;
    ctrl.alu     = ALU_NONE;
    ctrl.cmp_reg = REG_A;
    ctrl.wsel    = WS_MOD;
    unique case (op_t'(in_operation))
      OP_ADC: ctrl.alu = ALU_ADC;
      OP_SBC: ctrl.alu = ALU_SBC;
      OP_AND: ctrl.alu = ALU_AND;
      OP_ORA: ctrl.alu = ALU_ORA;
      OP_EOR: ctrl.alu = ALU_EOR;
      OP_ASL: begin
        ctrl.modify = MOD_ASL; ctrl.wen = 1'b1; ctrl.nz_mod = 1'b1;
      end
      OP_LSR: begin
        ctrl.modify = MOD_LSR; ctrl.wen = 1'b1; ctrl.nz_mod = 1'b1;
      end
      OP_ROL: begin
        ctrl.modify = MOD_ROL; ctrl.wen = 1'b1; ctrl.nz_mod = 1'b1;
      end
      OP_ROR: begin
        ctrl.modify = MOD_ROR; ctrl.wen = 1'b1; ctrl.nz_mod = 1'b1;
      end
      OP_BIT: ctrl.alu = ALU_BIT;
      OP_JMP: ctrl.jump = 1'b1;
      OP_CMP: begin
        ctrl.alu = ALU_CMP; ctrl.cmp_reg = REG_A;
      end
      OP_CPX: begin
        ctrl.alu = ALU_CMP; ctrl.cmp_reg = REG_X;
      end
      OP_CPY: begin
        ctrl.alu = ALU_CMP; ctrl.cmp_reg = REG_Y;
      end
      OP_INC: begin
        ctrl.modify = MOD_INC; ctrl.wen = 1'b1; ctrl.nz_mod = 1'b1;
      end
      OP_DEC: begin
        ctrl.modify = MOD_DEC; ctrl.wen = 1'b1; ctrl.nz_mod = 1'b1;
      end
      OP_LDA: begin
        ctrl.alu = ALU_LOAD; ctrl.ld_a = 1'b1;
      end
      OP_LDX: begin
        ctrl.alu = ALU_LOAD; ctrl.ld_x = 1'b1;
      end
      OP_LDY: begin
        ctrl.alu = ALU_LOAD; ctrl.ld_y = 1'b1;
      end
      OP_STA: begin
        ctrl.wen = 1'b1; ctrl.wsel = WS_A;
      end
      OP_STX: begin
        ctrl.wen = 1'b1; ctrl.wsel = WS_X;
      end
      OP_STY: begin
        ctrl.wen = 1'b1; ctrl.wsel = WS_Y;
      end
      OP_LAX: begin
        ctrl.alu = ALU_LOAD; ctrl.ld_a = 1'b1; ctrl.ld_x = 1'b1;
      end
      OP_SAX: begin
        ctrl.wen = 1'b1; ctrl.wsel = WS_AX;
      end
      OP_DCP: begin
        ctrl.modify = MOD_DEC; ctrl.wen = 1'b1;
        ctrl.alu = ALU_CMP; ctrl.cmp_reg = REG_A;
      end
      OP_ISC: begin
        ctrl.modify = MOD_INC; ctrl.wen = 1'b1; ctrl.alu = ALU_SBC;
      end
      OP_SLO: begin
        ctrl.modify = MOD_ASL; ctrl.wen = 1'b1; ctrl.alu = ALU_ORA;
      end
      OP_RLA: begin
        ctrl.modify = MOD_ROL; ctrl.wen = 1'b1; ctrl.alu = ALU_AND;
      end
      OP_SRE: begin
        ctrl.modify = MOD_LSR; ctrl.wen = 1'b1; ctrl.alu = ALU_EOR;
      end
      OP_RRA: begin
        ctrl.modify = MOD_ROR; ctrl.wen = 1'b1; ctrl.alu = ALU_ADC;
      end
      // Unused codes leave every control bit inactive.
      default: ctrl.alu = ALU_NONE;
    endcase
  end

  assign push_uop = '{ctrl: ctrl, operand: in_operand_value, address: in_operand_address};

endmodule

// ----- src/cpu8mo_queue.sv -----
// ---------------------------------------------------------------------------
// cpu8mo_queue
// Small first-in first-out buffer of decoded requests.
// ---------------------------------------------------------------------------
`include "cpu8_memory_operand_execute_top_defines.svh"

module cpu8mo_queue
  import cpu8mo_pkg::*;
#(
  parameter int DEPTH = CPU8MO_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  uop_t    push_uop,
  input  logic    pop,
  output logic    full,
  output q_head_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  uop_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = (count_r == CntW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.uop   = mem_r[rd_ptr_r];

  // Pointer advance with wrap at the last entry.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
  end

  // Occupancy count.
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_uop;
    end
  end

  `CPU8MO_ASSERT_SAME(a_no_pop_empty, pop, count_r != '0, "queue popped while empty")
  `CPU8MO_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CntW'(DEPTH), "queue count overflow")

endmodule

// ----- src/cpu8mo_back.sv -----
// ---------------------------------------------------------------------------
// cpu8mo_back
// Executes decoded requests against A, X, Y and the flags, one per cycle while the result is not stalled.
// ---------------------------------------------------------------------------
`include "cpu8_memory_operand_execute_top_defines.svh"

module cpu8mo_back
  import cpu8mo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  q_head_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_enable,
  output logic [7:0]  out_write_data,
  output logic        out_jump_taken,
  output logic [15:0] out_jump_target,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_xreg_out,
  output logic [7:0]  out_yreg_out,
  output logic [3:0]  out_flags_out
);

  // Architectural state.
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic [3:0] flags_r, flags_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        we_r;
  logic [7:0]  wd_r;
  logic        jump_r;
  logic [15:0] jt_r;

  ctrl_t       ctrl;
  logic [7:0]  m;
  logic [7:0]  mv;
  logic        sc;
  logic        is_shift;
  logic        c_in;
  logic        c_mod;
  logic [7:0]  b;
  logic [8:0]  sum;
  logic [7:0]  r;
  logic [8:0]  diff;
  logic [7:0]  res;
  logic [7:0]  wdata;
  logic        n, v, z, c;

  assign ctrl = head.uop.ctrl;
  assign m    = head.uop.operand;
  assign c_in = flags_r[FLAG_C];

  // Take the next request when the output register is free or being drained.
  assign pop = head.valid && (!out_valid_r || !out_stall);

  // Operand modification: shifts, rotates, increment and decrement.
  always_comb begin
    sc       = 1'b0;
    is_shift = 1'b0;
    unique case (ctrl.modify)
      MOD_ASL: begin
        mv = {m[6:0], 1'b0}; sc = m[7]; is_shift = 1'b1;
      end
      MOD_LSR: begin
        mv = {1'b0, m[7:1]}; sc = m[0]; is_shift = 1'b1;
      end
      MOD_ROL: begin
        mv = {m[6:0], c_in}; sc = m[7]; is_shift = 1'b1;
      end
      MOD_ROR: begin
        mv = {c_in, m[7:1]}; sc = m[0]; is_shift = 1'b1;
      end
      MOD_INC: mv = m + 8'd1;
      MOD_DEC: mv = m - 8'd1;
      default: mv = m;
    endcase
    c_mod = is_shift ? sc : c_in;
  end

  // Binary adder shared by ADC and SBC; SBC adds the inverted operand.
  always_comb begin
    b   = (ctrl.alu == ALU_SBC) ? ~mv : mv;
    sum = {1'b0, acc_r} + {1'b0, b} + {8'd0, c_mod};
  end

  // Compare subtractor.
  always_comb begin
    unique case (ctrl.cmp_reg)
      REG_X:   r = x_r;
      REG_Y:   r = y_r;
      default: r = acc_r;
    endcase
    diff = {1'b0, r} - {1'b0, mv};
  end

  // Accumulator path, register loads and flag updates.
  always_comb begin
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    n       = flags_r[FLAG_N];
    v       = flags_r[FLAG_V];
    z       = flags_r[FLAG_Z];
    c       = c_mod;
    res     = 8'd0;
    if (ctrl.nz_mod) begin
      n = mv[7];
      z = (mv == 8'd0);
    end
    unique case (ctrl.alu)
      ALU_ADC, ALU_SBC: begin
        acc_nxt = sum[7:0];
        c = sum[8];
        v = ~(acc_r[7] ^ b[7]) & (acc_r[7] ^ sum[7]);
        n = sum[7];
        z = (sum[7:0] == 8'd0);
      end
      ALU_AND, ALU_ORA, ALU_EOR: begin
        if (ctrl.alu == ALU_AND) begin
          res = acc_r & mv;
        end else if (ctrl.alu == ALU_ORA) begin
          res = acc_r | mv;
        end else begin
          res = acc_r ^ mv;
        end
        acc_nxt = res;
        n = res[7];
        z = (res == 8'd0);
      end
      ALU_BIT: begin
        n = m[7];
        v = m[6];
        z = ((acc_r & m) == 8'd0);
      end
      ALU_CMP: begin
        c = ~diff[8];
        n = diff[7];
        z = (diff[7:0] == 8'd0);
      end
      ALU_LOAD: begin
        if (ctrl.ld_a) acc_nxt = m;
        if (ctrl.ld_x) x_nxt = m;
        if (ctrl.ld_y) y_nxt = m;
        n = m[7];
        z = (m == 8'd0);
      end
      default: res = 8'd0;
    endcase
    flags_nxt = {n, v, z, c};
  end

  // Write-back byte selection.
  always_comb begin
    unique case (ctrl.wsel)
      WS_A:    wdata = acc_r;
      WS_X:    wdata = x_r;
      WS_Y:    wdata = y_r;
      WS_AX:   wdata = acc_r & x_r;
      default: wdata = mv;
    endcase
  end

  // Output valid: set on a new request, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        acc_r   <= acc_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  // Result payload; the register file outputs show the committed state.
  always_ff @(posedge clk) begin
    if (pop) begin
      we_r   <= ctrl.wen;
      wd_r   <= ctrl.wen ? wdata : 8'd0;
      jump_r <= ctrl.jump;
      jt_r   <= ctrl.jump ? head.uop.address : 16'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_write_data   = wd_r;
  assign out_jump_taken   = jump_r;
  assign out_jump_target  = jt_r;
  assign out_acc_out      = acc_r;
  assign out_xreg_out     = x_r;
  assign out_yreg_out     = y_r;
  assign out_flags_out    = flags_r;

  `CPU8MO_ASSERT_NEXT(a_hold_state, out_valid_r && out_stall, $stable(acc_r) && $stable(flags_r) && $stable(x_r) && $stable(y_r), "state changed while result stalled")
  `CPU8MO_ASSERT_NEXT(a_pop_shows, pop, out_valid_r, "popped request produced no result")
  `CPU8MO_ASSERT_SAME(a_jump_no_write, out_valid_r && jump_r, !we_r, "jump result also writes memory")

endmodule

// ----- src/cpu8_memory_operand_execute_top.sv -----
// ---------------------------------------------------------------------------
// cpu8_memory_operand_execute_top
// Execute unit for 8-bit memory-operand instructions with A, X, Y and NVZC.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall) carries one request per accepted
//   cycle: an operation code, the operand byte and its effective address.
//   The result channel (out_valid, out_stall) returns exactly one result per
//   request, in order: write-back enable and byte, jump flag and target, and
//   A, X, Y and the flags after the operation.
//   An accepted request passes through the queue into the output register
//   behind out_valid. Throughput is one request per cycle while the receiver
//   does not stall; the execute stage with its output register sets it.
//   A short queue sits between the decoder and the execute stage. While the
//   receiver stalls, the held result stays stable, the queue keeps taking
//   requests until it is full, and then in_stall rises.
//   Reset (synchronous, active low) clears A, X, Y, the flags, the queue and
//   the result valid; no result is pending afterwards.
// ---------------------------------------------------------------------------
module cpu8_memory_operand_execute_top
  import cpu8mo_pkg::*;
#(
  parameter int QUEUE_DEPTH = CPU8MO_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_operation,
  input  logic [7:0]  in_operand_value,
  input  logic [15:0] in_operand_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_enable,
  output logic [7:0]  out_write_data,
  output logic        out_jump_taken,
  output logic [15:0] out_jump_target,
  output logic [7:0]  out_acc_out,
  output logic [7:0]  out_xreg_out,
  output logic [7:0]  out_yreg_out,
  output logic [3:0]  out_flags_out
);

  logic    q_full;
  logic    push;
  uop_t    push_uop;
  logic    pop;
  q_head_t head;

  // Decode front end.
  cpu8mo_front u_front (
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_operand_value   (in_operand_value),
    .in_operand_address (in_operand_address),
    .q_full             (q_full),
    .push               (push),
    .push_uop           (push_uop)
  );

  // Request queue.
  cpu8mo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_uop (push_uop),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // Execute back end.
  cpu8mo_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_write_data   (out_write_data),
    .out_jump_taken   (out_jump_taken),
    .out_jump_target  (out_jump_target),
    .out_acc_out      (out_acc_out),
    .out_xreg_out     (out_xreg_out),
    .out_yreg_out     (out_yreg_out),
    .out_flags_out    (out_flags_out)
  );

endmodule

// ----- tb/sv/cpu8_memory_operand_execute_top_test.sv -----
// ---------------------------------------------------------------------------
// cpu8_memory_operand_execute_top_test
// Self-checking bench for the 8-bit memory-operand execute unit. It drives
// requests through the valid/stall input channel, predicts each result with
// its own model of A, X, Y and the NVZC flags, and compares every returned
// result field by field. In some phases both channels idle in random short bursts.
// ---------------------------------------------------------------------------
module cpu8_memory_operand_execute_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpu8mo_pkg::*;

  // Highest code; the codes above the operation set must act as no-ops.
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;
  localparam int MAX_REPORTS = 10;

  // One result as the unit returns it.
  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_data;
    logic        jump;
    logic [15:0] target;
    logic [7:0]  acc;
    logic [7:0]  xreg;
    logic [7:0]  yreg;
    logic [3:0]  flags;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_operation = '0;
  logic [7:0]  in_operand_value = '0;
  logic [15:0] in_operand_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_write_enable;
  logic [7:0]  out_write_data;
  logic        out_jump_taken;
  logic [15:0] out_jump_target;
  logic [7:0]  out_acc_out;
  logic [7:0]  out_xreg_out;
  logic [7:0]  out_yreg_out;
  logic [3:0]  out_flags_out;

  // Predicted architectural state.
  logic [7:0] mdl_acc = '0;
  logic [7:0] mdl_x = '0;
  logic [7:0] mdl_y = '0;
  logic [3:0] mdl_flags = '0;

  exec_result_t pending_results[$];
  int  mismatch_count = 0;
  bit  tx_gaps_on = 1'b0;
  bit  rx_stalls_on = 1'b0;
  int  stall_left = 0;

  cpu8_memory_operand_execute_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_operand_value   (in_operand_value),
    .in_operand_address (in_operand_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_enable   (out_write_enable),
    .out_write_data     (out_write_data),
    .out_jump_taken     (out_jump_taken),
    .out_jump_target    (out_jump_target),
    .out_acc_out        (out_acc_out),
    .out_xreg_out       (out_xreg_out),
    .out_yreg_out       (out_yreg_out),
    .out_flags_out      (out_flags_out)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // N and Z follow the given byte.
  function automatic void set_nz(logic [7:0] v);
    mdl_flags[FLAG_N] = v[7];
    mdl_flags[FLAG_Z] = (v == 8'h00);
  endfunction

  // Binary add with carry in; updates C, V, N and Z.
  function automatic logic [7:0] add_with_carry(logic [7:0] a, logic [7:0] v);
    logic [8:0] sum;
    sum = a + v + mdl_flags[FLAG_C];
    mdl_flags[FLAG_C] = sum[8];
    mdl_flags[FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
    set_nz(sum[7:0]);
    return sum[7:0];
  endfunction

  // Compare sets C when no borrow occurs, N and Z from the difference.
  function automatic void compare_reg(logic [7:0] r, logic [7:0] v);
    logic [7:0] diff;
    diff = r - v;
    set_nz(diff);
    mdl_flags[FLAG_C] = (r >= v);
  endfunction

  // Advances the predicted state by one request and returns its result.
  function automatic exec_result_t execute_request(logic [4:0] code, logic [7:0] m,
                                                   logic [15:0] addr);
    exec_result_t res;
    logic [7:0] wd;
    logic wr, jmp, cin;
    wd = '0;
    wr = 1'b0;
    jmp = 1'b0;
    cin = mdl_flags[FLAG_C];
    case (code)
      OP_ADC: mdl_acc = add_with_carry(mdl_acc, m);
      OP_SBC: mdl_acc = add_with_carry(mdl_acc, ~m);
      OP_AND: begin mdl_acc = mdl_acc & m; set_nz(mdl_acc); end
      OP_ORA: begin mdl_acc = mdl_acc | m; set_nz(mdl_acc); end
      OP_EOR: begin mdl_acc = mdl_acc ^ m; set_nz(mdl_acc); end
      OP_ASL: begin
        mdl_flags[FLAG_C] = m[7]; wd = {m[6:0], 1'b0}; set_nz(wd); wr = 1'b1;
      end
      OP_LSR: begin
        mdl_flags[FLAG_C] = m[0]; wd = {1'b0, m[7:1]}; set_nz(wd); wr = 1'b1;
      end
      OP_ROL: begin
        mdl_flags[FLAG_C] = m[7]; wd = {m[6:0], cin}; set_nz(wd); wr = 1'b1;
      end
      OP_ROR: begin
        mdl_flags[FLAG_C] = m[0]; wd = {cin, m[7:1]}; set_nz(wd); wr = 1'b1;
      end
      OP_BIT: begin
        mdl_flags[FLAG_N] = m[7];
        mdl_flags[FLAG_V] = m[6];
        mdl_flags[FLAG_Z] = ((mdl_acc & m) == 8'h00);
      end
      OP_JMP: jmp = 1'b1;
      OP_CMP: compare_reg(mdl_acc, m);
      OP_CPX: compare_reg(mdl_x, m);
      OP_CPY: compare_reg(mdl_y, m);
      OP_INC: begin wd = m + 8'd1; set_nz(wd); wr = 1'b1; end
      OP_DEC: begin wd = m - 8'd1; set_nz(wd); wr = 1'b1; end
      OP_LDA: begin mdl_acc = m; set_nz(m); end
      OP_LDX: begin mdl_x = m; set_nz(m); end
      OP_LDY: begin mdl_y = m; set_nz(m); end
      OP_STA: begin wd = mdl_acc; wr = 1'b1; end
      OP_STX: begin wd = mdl_x; wr = 1'b1; end
      OP_STY: begin wd = mdl_y; wr = 1'b1; end
      OP_LAX: begin mdl_acc = m; mdl_x = m; set_nz(m); end
      OP_SAX: begin wd = mdl_acc & mdl_x; wr = 1'b1; end
      OP_DCP: begin wd = m - 8'd1; wr = 1'b1; compare_reg(mdl_acc, wd); end
      OP_ISC: begin wd = m + 8'd1; wr = 1'b1; mdl_acc = add_with_carry(mdl_acc, ~wd); end
      OP_SLO: begin
        mdl_flags[FLAG_C] = m[7]; wd = {m[6:0], 1'b0}; wr = 1'b1;
        mdl_acc = mdl_acc | wd; set_nz(mdl_acc);
      end
      OP_RLA: begin
        mdl_flags[FLAG_C] = m[7]; wd = {m[6:0], cin}; wr = 1'b1;
        mdl_acc = mdl_acc & wd; set_nz(mdl_acc);
      end
      OP_SRE: begin
        mdl_flags[FLAG_C] = m[0]; wd = {1'b0, m[7:1]}; wr = 1'b1;
        mdl_acc = mdl_acc ^ wd; set_nz(mdl_acc);
      end
      // The add takes the carry that the rotate just produced.
      OP_RRA: begin
        mdl_flags[FLAG_C] = m[0]; wd = {cin, m[7:1]}; wr = 1'b1;
        mdl_acc = add_with_carry(mdl_acc, wd);
      end
      default: ;
    endcase
    res.wr_en   = wr;
    res.wr_data = wr ? wd : 8'h00;
    res.jump    = jmp;
    res.target  = jmp ? addr : 16'h0000;
    res.acc     = mdl_acc;
    res.xreg    = mdl_x;
    res.yreg    = mdl_y;
    res.flags   = mdl_flags;
    return res;
  endfunction

  // Presents one request, holds it until accepted and records its prediction.
  task automatic send_request(logic [4:0] code, logic [7:0] m, logic [15:0] addr);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= code;
    in_operand_value   <= m;
    in_operand_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(execute_request(code, m, addr));
  endtask

  // Receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    exec_result_t got, want;
    bit bad;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_write_enable, out_write_data, out_jump_taken, out_jump_target,
              out_acc_out, out_xreg_out, out_yreg_out, out_flags_out};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR %0t: result with nothing pending: %p", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        bad = (got.wr_en !== want.wr_en) || (got.wr_data !== want.wr_data) ||
              (got.jump !== want.jump) || (got.target !== want.target) ||
              (got.acc !== want.acc) || (got.xreg !== want.xreg) ||
              (got.yreg !== want.yreg) || (got.flags !== want.flags);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR %0t: result mismatch", $realtime);
            $display("  expected we=%b wd=%h jmp=%b tgt=%h a=%h x=%h y=%h nvzc=%b",
                     want.wr_en, want.wr_data, want.jump, want.target,
                     want.acc, want.xreg, want.yreg, want.flags);
            $display("  actual   we=%b wd=%h jmp=%b tgt=%h a=%h x=%h y=%h nvzc=%b",
                     got.wr_en, got.wr_data, got.jump, got.target,
                     got.acc, got.xreg, got.yreg, got.flags);
          end
        end
      end
    end
  end

  // Every code once, including the two unused ones, with extreme operands.
  task automatic test_every_operation();
    logic [7:0] extremes[6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h40};
    for (int code = 0; code <= OP_UNUSED_HI; code++)
      send_request(code[4:0], extremes[code % 6], code[0] ? 16'hFFFF : 16'h0000);
  endtask

  // Signed overflow, carry out, borrowing compare, wrapping read-modify-write.
  task automatic test_arith_corners();
    send_request(OP_LDA, 8'h7F, 16'h1234);
    send_request(OP_ADC, 8'h01, 16'h1234);
    send_request(OP_ADC, 8'h80, 16'h1234);
    send_request(OP_SBC, 8'h00, 16'h1234);
    send_request(OP_CMP, 8'h01, 16'h1234);
    send_request(OP_RRA, 8'h01, 16'h1234);
    send_request(OP_ISC, 8'hFF, 16'h1234);
    send_request(OP_DCP, 8'h00, 16'h1234);
  endtask

  // Random requests; operands and addresses lean toward the extremes now and then.
  task automatic test_random_mix(int count);
    logic [7:0]  m;
    logic [15:0] addr;
    logic [4:0]  code;
    for (int i = 0; i < count; i++) begin
      code = 5'($urandom_range(0, OP_UNUSED_HI));
      case ($urandom_range(0, 7))
        0: m = 8'h00;
        1: m = 8'hFF;
        2: m = 8'h80 ^ 8'($urandom_range(0, 1));
        default: m = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0: addr = 16'h0000;
        1: addr = 16'hFFFF;
        default: addr = 16'($urandom_range(0, 65535));
      endcase
      send_request(code, m, addr);
    end
  endtask

  // Run limit.
  initial begin
    #2_000_000;
    $display("cpu8_memory_operand_execute_top_test NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    test_every_operation();
    test_arith_corners();
    test_random_mix(600);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    test_random_mix(300);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    test_random_mix(600);
    // Closing stretch runs at full rate on both sides.
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    test_random_mix(300);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("cpu8_memory_operand_execute_top_test OK");
    end else begin
      $display("cpu8_memory_operand_execute_top_test NOT OK");
    end
    $finish;
  end

endmodule
